// ----- hw/rtl/pvsc_pkg.sv -----
// shared types, constants and the code-to-voltage decoder of the voltage selector codec
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package pvsc_pkg;

  // operations
  localparam logic [1:0] KIND_SELECT = 2'd0;
  localparam logic [1:0] KIND_LIST   = 2'd1;
  localparam logic [1:0] KIND_RAMP   = 2'd2;

  // rails
  localparam logic [3:0] RAIL_BUCK2 = 4'd2;
  localparam logic [3:0] RAIL_BUCK3 = 4'd3;
  localparam logic [3:0] NUM_BUCKS  = 4'd4;
  localparam logic [3:0] NUM_RAILS  = 4'd10;

  // selector codes
  localparam logic [5:0] CODE_FINE_TOP = 6'h3b;
  localparam logic [5:0] CODE_COARSE   = 6'h3c;
  localparam logic [5:0] CODE_TOP      = 6'h3f;
  localparam logic [5:0] CODE_B3_TOP   = 6'h1b;
  localparam logic [5:0] CODE_LDO_TOP  = 6'h1f;

  // voltages in microvolts
  localparam logic [21:0] V_BUCK_BASE     = 22'd712500;
  localparam logic [21:0] V_BUCK_FINE_TOP = 22'd1450000;
  localparam logic [21:0] V_BUCK_COARSE   = 22'd1800000;
  localparam logic [21:0] V_BUCK_TOP      = 22'd2300000;
  localparam logic [21:0] V_BUCK2_FIXED   = 22'd1200000;
  localparam logic [21:0] V_LDO_BASE      = 22'd800000;
  localparam logic [21:0] V_B3_TOP        = 22'd3500000;
  localparam logic [21:0] V_LDO_TOP       = 22'd3400000;
  localparam logic [21:0] STEP_FINE       = 22'd12500;
  localparam logic [21:0] STEP_COARSE     = 22'd200000;
  localparam logic [21:0] STEP_LDO        = 22'd100000;
  localparam logic [21:0] V_COARSE_1      = V_BUCK_COARSE + STEP_COARSE;
  localparam logic [21:0] V_COARSE_2      = V_BUCK_COARSE + STEP_COARSE + STEP_COARSE;

  // ramp: ceil(d / 6250) = floor((d + 6249) / 2 / 3125)
  localparam logic [22:0] RAMP_BIAS = 23'd6249;

  // x / 3125 = (x * RECIP) >> RECIP_SHIFT, exact for x below 2^21
  localparam int          RECIP_SHIFT = 32;
  localparam logic [20:0] RECIP       = 21'd1374390;

  typedef struct packed {
    logic        ok;
    logic [21:0] uv;
  } dec_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        err;
    logic [3:0]  rail;
    logic [21:0] mx;
    logic [21:0] vo;
    logic [21:0] vn;
    logic [21:0] sel_dvd;
    logic        sel_fixed;
    logic [5:0]  sel_code;
    logic        sel_shift;
  } s1_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        err;
    logic [3:0]  rail;
    logic [21:0] mx;
    logic [21:0] vo;
    logic [20:0] y;
    logic        sel_fixed;
    logic [5:0]  sel_code;
    logic        sel_shift;
  } s2_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        err;
    logic [3:0]  rail;
    logic [21:0] mx;
    logic [21:0] vo;
    logic [41:0] prod;
    logic        sel_fixed;
    logic [5:0]  sel_code;
    logic        sel_shift;
  } s3_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        err;
    logic [21:0] mx;
    logic [21:0] vo;
    logic [5:0]  code;
    logic [21:0] vsel;
    logic [9:0]  ramp;
  } s4_t;

  function automatic dec_t decode_uv(input logic [3:0] rail, input logic [5:0] code);
    dec_t       r;
    logic [5:0] c3;
    r.ok = 1'b1;
    r.uv = '0;
    c3   = (code > CODE_B3_TOP) ? CODE_B3_TOP : code;
    if (rail < RAIL_BUCK2) begin
      if (code <= CODE_FINE_TOP) begin
        r.uv = V_BUCK_BASE + 22'(code) * STEP_FINE;
      end else if (code < CODE_TOP) begin
        r.uv = V_BUCK_COARSE + 22'(code - CODE_COARSE) * STEP_COARSE;
      end else begin
        r.uv = V_BUCK_TOP;
      end
    end else if (rail == RAIL_BUCK2) begin
      r.uv = V_BUCK2_FIXED;
    end else if (rail == RAIL_BUCK3) begin
      r.uv = V_LDO_BASE + 22'(c3) * STEP_LDO;
    end else if (rail < NUM_RAILS && code <= CODE_LDO_TOP) begin
      r.uv = V_LDO_BASE + 22'(code) * STEP_LDO;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/pvsc_front.sv -----
// first stage: decodes both codes, classifies the select request and
// forms the select dividend; depends on pvsc_pkg
`timescale 1ns / 1ps

module pvsc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  logic [3:0]           rail,
  input  logic [21:0]          min_uv,
  input  logic [21:0]          max_uv,
  input  logic [5:0]           code_a,
  input  logic [5:0]           code_b,
  output logic                 s1_valid,
  output pvsc_pkg::s1_t        s1,
  input  logic                 s1_ready_next
);

  pvsc_pkg::s1_t  s1_next;
  pvsc_pkg::dec_t dec_a;
  pvsc_pkg::dec_t dec_b;
  logic           s1_ready;

  assign s1_ready = !s1_valid || s1_ready_next;
  assign in_ready = s1_ready;

  always_comb begin
    dec_a = pvsc_pkg::decode_uv(rail, code_a);
    dec_b = pvsc_pkg::decode_uv(rail, code_b);

    s1_next.op        = kind;
    s1_next.err       = 1'b0;
    s1_next.rail      = rail;
    s1_next.mx        = max_uv;
    s1_next.vo        = dec_a.uv;
    s1_next.vn        = dec_b.uv;
    s1_next.sel_dvd   = '0;
    s1_next.sel_fixed = 1'b1;
    s1_next.sel_code  = '0;
    s1_next.sel_shift = 1'b0;

    // select classification by rail
    if (rail < pvsc_pkg::RAIL_BUCK2) begin
      if (min_uv < pvsc_pkg::V_BUCK_BASE) begin
        s1_next.sel_code = '0;
      end else if (min_uv <= pvsc_pkg::V_BUCK_FINE_TOP) begin
        s1_next.sel_fixed = 1'b0;
        s1_next.sel_dvd   = min_uv - pvsc_pkg::V_BUCK_BASE;
      end else if (min_uv < pvsc_pkg::V_BUCK_COARSE) begin
        s1_next.sel_code = pvsc_pkg::CODE_FINE_TOP;
      end else if (min_uv < pvsc_pkg::V_BUCK_TOP) begin
        s1_next.sel_code = pvsc_pkg::CODE_COARSE
                         + {5'b0, min_uv >= pvsc_pkg::V_COARSE_1}
                         + {5'b0, min_uv >= pvsc_pkg::V_COARSE_2};
      end else if (min_uv == pvsc_pkg::V_BUCK_TOP) begin
        s1_next.sel_code = pvsc_pkg::CODE_TOP;
      end else begin
        s1_next.err = (kind == pvsc_pkg::KIND_SELECT);
      end
    end else if (rail == pvsc_pkg::RAIL_BUCK2) begin
      s1_next.sel_code = '0;
    end else if (min_uv < pvsc_pkg::V_LDO_BASE) begin
      s1_next.sel_code = '0;
    end else if ((rail == pvsc_pkg::RAIL_BUCK3 && min_uv <= pvsc_pkg::V_B3_TOP) ||
                 (rail != pvsc_pkg::RAIL_BUCK3 && min_uv <= pvsc_pkg::V_LDO_TOP)) begin
      // steps of 100 mV: divide by 12500, then by 8
      s1_next.sel_fixed = 1'b0;
      s1_next.sel_shift = 1'b1;
      s1_next.sel_dvd   = min_uv - pvsc_pkg::V_LDO_BASE;
    end else begin
      s1_next.err = (kind == pvsc_pkg::KIND_SELECT);
    end

    case (kind)
      pvsc_pkg::KIND_SELECT: ;
      pvsc_pkg::KIND_LIST:   s1_next.err = !dec_a.ok;
      pvsc_pkg::KIND_RAMP:   s1_next.err = (rail >= pvsc_pkg::NUM_BUCKS);
      default:               s1_next.err = 1'b1;
    endcase
    if (rail >= pvsc_pkg::NUM_RAILS) begin
      s1_next.err = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1 <= s1_next;
    end
  end

endmodule

// ----- hw/rtl/pvsc_div.sv -----
// second and third stages: picks the dividend and multiplies it by the
// reciprocal of 3125; depends on pvsc_pkg
`timescale 1ns / 1ps

module pvsc_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          s1_valid,
  input  pvsc_pkg::s1_t s1,
  output logic          s1_ready,
  output logic          s3_valid,
  output pvsc_pkg::s3_t s3,
  input  logic          s3_ready_next
);

  pvsc_pkg::s2_t s2;
  pvsc_pkg::s2_t s2_next;
  pvsc_pkg::s3_t s3_next;
  logic          s2_valid;
  logic          s3_ready;
  logic [21:0]   diff;
  logic [22:0]   bias_sum;

  assign s3_ready = !s3_valid || s3_ready_next;
  assign s1_ready = !s2_valid || s3_ready;

  always_comb begin
    diff     = (s1.vo > s1.vn) ? (s1.vo - s1.vn) : (s1.vn - s1.vo);
    bias_sum = 23'(diff) + pvsc_pkg::RAMP_BIAS;

    s2_next.op        = s1.op;
    s2_next.err       = s1.err;
    s2_next.rail      = s1.rail;
    s2_next.mx        = s1.mx;
    s2_next.vo        = s1.vo;
    s2_next.sel_fixed = s1.sel_fixed;
    s2_next.sel_code  = s1.sel_code;
    s2_next.sel_shift = s1.sel_shift;
    // ramp: (d + 6249) / 2; select: dividend / 4
    if (s1.op == pvsc_pkg::KIND_RAMP) begin
      s2_next.y = bias_sum[21:1];
    end else begin
      s2_next.y = {1'b0, s1.sel_dvd[21:2]};
    end
  end

  always_comb begin
    s3_next.op        = s2.op;
    s3_next.err       = s2.err;
    s3_next.rail      = s2.rail;
    s3_next.mx        = s2.mx;
    s3_next.vo        = s2.vo;
    s3_next.prod      = 42'(s2.y) * 42'(pvsc_pkg::RECIP);
    s3_next.sel_fixed = s2.sel_fixed;
    s3_next.sel_code  = s2.sel_code;
    s3_next.sel_shift = s2.sel_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      s2 <= s2_next;
    end
    if (s3_ready && s2_valid) begin
      s3 <= s3_next;
    end
  end

endmodule

// ----- hw/rtl/pvsc_back.sv -----
// fourth and fifth stages: takes the quotient, forms the code and its voltage,
// checks the maximum and holds the result beat; depends on pvsc_pkg
`timescale 1ns / 1ps

module pvsc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          s3_valid,
  input  pvsc_pkg::s3_t s3,
  output logic          s3_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [5:0]    code_out,
  output logic [21:0]   voltage_uv,
  output logic [9:0]    ramp_units,
  output logic          error
);

  pvsc_pkg::s4_t  s4;
  pvsc_pkg::s4_t  s4_next;
  pvsc_pkg::dec_t dec_sel;
  logic           s4_valid;
  logic           out_stage_ready;
  logic [9:0]     quot;
  logic [5:0]     code_next;
  logic [5:0]     code_res;
  logic [21:0]    volt_res;
  logic [9:0]     ramp_res;
  logic           err_res;

  assign out_stage_ready = !out_valid || out_ready;
  assign s3_ready        = !s4_valid || out_stage_ready;

  always_comb begin
    quot = s3.prod[pvsc_pkg::RECIP_SHIFT +: 10];
    if (s3.sel_fixed) begin
      code_next = s3.sel_code;
    end else if (s3.sel_shift) begin
      code_next = quot[8:3];
    end else begin
      code_next = quot[5:0];
    end
    dec_sel      = pvsc_pkg::decode_uv(s3.rail, code_next);
    s4_next.op   = s3.op;
    s4_next.err  = s3.err;
    s4_next.mx   = s3.mx;
    s4_next.vo   = s3.vo;
    s4_next.code = code_next;
    s4_next.vsel = dec_sel.uv;
    s4_next.ramp = quot;
  end

  always_comb begin
    err_res  = s4.err || (s4.op == pvsc_pkg::KIND_SELECT && s4.vsel > s4.mx);
    code_res = '0;
    volt_res = '0;
    ramp_res = '0;
    if (!err_res) begin
      case (s4.op)
        pvsc_pkg::KIND_SELECT: code_res = s4.code;
        pvsc_pkg::KIND_LIST:   volt_res = s4.vo;
        pvsc_pkg::KIND_RAMP:   ramp_res = s4.ramp;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s3_ready) begin
        s4_valid <= s3_valid;
      end
      if (out_stage_ready) begin
        out_valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s3_valid) begin
      s4 <= s4_next;
    end
    if (out_stage_ready && s4_valid) begin
      code_out   <= code_res;
      voltage_uv <= volt_res;
      ramp_units <= ramp_res;
      error      <= err_res;
    end
  end

endmodule

// ----- hw/rtl/pmic_voltage_selector_codec.sv -----
// top level of the voltage selector codec for four buck and six ldo rails
// chains pvsc_front, pvsc_div and pvsc_back; depends on pvsc_pkg
`timescale 1ns / 1ps

// usage:
// input beats carry kind (select, list, ramp), rail, min_uv/max_uv for select
// and code_a/code_b for list and ramp; both channels use valid/ready.
// every input beat yields exactly one output beat with code_out, voltage_uv,
// ramp_units and error; fields that do not belong to the operation are zero,
// and all of them are zero when error is set.
// the datapath is five register stages: decode and classify, dividend,
// reciprocal multiply, code and voltage, output register; an accepted beat
// passes through them in that order before out_valid rises.
// one beat per cycle is accepted and delivered steadily while out_ready
// stays high; the multiply by the reciprocal of 3125 sits in a stage of
// its own.
// each stage has its own valid bit and loads when empty or when the stage
// after it moves, so a stalled receiver backs up stage by stage and gaps
// close up; in_ready falls only when all five stages hold beats.
// synchronous reset clears every valid bit; no beat survives reset.

module pmic_voltage_selector_codec (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [3:0]  rail,
  input  logic [21:0] min_uv,
  input  logic [21:0] max_uv,
  input  logic [5:0]  code_a,
  input  logic [5:0]  code_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  code_out,
  output logic [21:0] voltage_uv,
  output logic [9:0]  ramp_units,
  output logic        error
);

  pvsc_pkg::s1_t s1;
  pvsc_pkg::s3_t s3;
  logic          s1_valid;
  logic          s1_ready;
  logic          s3_valid;
  logic          s3_ready;

  pvsc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .rail          (rail),
    .min_uv        (min_uv),
    .max_uv        (max_uv),
    .code_a        (code_a),
    .code_b        (code_b),
    .s1_valid      (s1_valid),
    .s1            (s1),
    .s1_ready_next (s1_ready)
  );

  pvsc_div u_div (
    .clk           (clk),
    .rst           (rst),
    .s1_valid      (s1_valid),
    .s1            (s1),
    .s1_ready      (s1_ready),
    .s3_valid      (s3_valid),
    .s3            (s3),
    .s3_ready_next (s3_ready)
  );

  pvsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .s3_valid   (s3_valid),
    .s3         (s3),
    .s3_ready   (s3_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_out   (code_out),
    .voltage_uv (voltage_uv),
    .ramp_units (ramp_units),
    .error      (error)
  );

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench for pmic_voltage_selector_codec: directed table, then random beats
// under three idle/stall profiles; depends on pvsc_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_top;
  import pvsc_pkg::*;

  localparam logic [1:0]  KIND_BAD   = 2'd3;
  localparam logic [21:0] UV_ALL     = 22'h3fffff;
  localparam int          STALL_MAX  = 2000;
  localparam int          PHASE_BEATS = 167;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  rail;
    logic [21:0] min_uv;
    logic [21:0] max_uv;
    logic [5:0]  code_a;
    logic [5:0]  code_b;
  } req_t;

  typedef struct packed {
    logic [5:0]  code;
    logic [21:0] uv;
    logic [9:0]  ramp;
    logic        err;
  } conv_t;

  typedef struct packed {
    req_t  req;
    logic  typed;
    conv_t want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = '0;
  logic [3:0]  rail = '0;
  logic [21:0] min_uv = '0;
  logic [21:0] max_uv = '0;
  logic [5:0]  code_a = '0;
  logic [5:0]  code_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  code_out;
  logic [21:0] voltage_uv;
  logic [9:0]  ramp_units;
  logic        error;

  conv_t expected_conv[$];
  row_t  directed_rows[$];
  int    mismatch_cnt = 0;
  int    src_idle_pct = 26;
  int    snk_stall_pct = 73;
  int    quiet_cycles = 0;

  pmic_voltage_selector_codec dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .rail       (rail),
    .min_uv     (min_uv),
    .max_uv     (max_uv),
    .code_a     (code_a),
    .code_b     (code_b),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_out   (code_out),
    .voltage_uv (voltage_uv),
    .ramp_units (ramp_units),
    .error      (error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // microvolts of a code on a rail; ok low for an ldo code past the top or a rail past the last
  function automatic logic [21:0] rail_volts(input logic [3:0] r, input logic [5:0] c,
                                             output logic ok);
    int v;
    ok = 1'b1;
    v  = 0;
    if (r < RAIL_BUCK2) begin
      if (c <= CODE_FINE_TOP) v = int'(V_BUCK_BASE) + int'(c) * int'(STEP_FINE);
      else if (c != CODE_TOP) v = int'(V_BUCK_COARSE) + int'(c - CODE_COARSE) * int'(STEP_COARSE);
      else v = int'(V_BUCK_TOP);
    end else if (r == RAIL_BUCK2) begin
      v = int'(V_BUCK2_FIXED);
    end else if (r == RAIL_BUCK3) begin
      v = int'(V_LDO_BASE) + int'((c > CODE_B3_TOP) ? CODE_B3_TOP : c) * int'(STEP_LDO);
    end else if (r < NUM_RAILS && c <= CODE_LDO_TOP) begin
      v = int'(V_LDO_BASE) + int'(c) * int'(STEP_LDO);
    end else begin
      ok = 1'b0;
    end
    return 22'(v);
  endfunction

  // code for the requested minimum, rounding down within a step
  function automatic logic pick_code(input logic [3:0] r, input logic [21:0] mn,
                                     output logic [5:0] c);
    int m;
    m = int'(mn);
    c = '0;
    if (r < RAIL_BUCK2) begin
      if (m < int'(V_BUCK_BASE)) c = '0;
      else if (m <= int'(V_BUCK_FINE_TOP)) c = 6'((m - int'(V_BUCK_BASE)) / int'(STEP_FINE));
      else if (m < int'(V_BUCK_COARSE)) c = CODE_FINE_TOP;
      else if (m < int'(V_BUCK_TOP))
        c = CODE_COARSE + 6'((m - int'(V_BUCK_COARSE)) / int'(STEP_COARSE));
      else if (m == int'(V_BUCK_TOP)) c = CODE_TOP;
      else return 1'b0;
    end else if (r == RAIL_BUCK3) begin
      if (m < int'(V_LDO_BASE)) c = '0;
      else if (m <= int'(V_B3_TOP)) c = 6'((m - int'(V_LDO_BASE)) / int'(STEP_LDO));
      else return 1'b0;
    end else if (r != RAIL_BUCK2) begin
      if (m < int'(V_LDO_BASE)) c = '0;
      else if (m <= int'(V_LDO_TOP)) c = 6'((m - int'(V_LDO_BASE)) / int'(STEP_LDO));
      else return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic conv_t convert_beat(input req_t q);
    conv_t       r;
    logic [5:0]  c;
    logic [21:0] v;
    logic        okc;
    logic        okv;
    int          vo;
    int          vn;
    int          d;
    r = '0;
    if (q.rail >= NUM_RAILS || q.kind == KIND_BAD) begin
      r.err = 1'b1;
    end else if (q.kind == KIND_SELECT) begin
      okc = pick_code(q.rail, q.min_uv, c);
      okv = 1'b0;
      v   = '0;
      if (okc) v = rail_volts(q.rail, c, okv);
      if (!okc || !okv || v > q.max_uv) r.err = 1'b1;
      else r.code = c;
    end else if (q.kind == KIND_LIST) begin
      v = rail_volts(q.rail, q.code_a, okv);
      if (okv) r.uv = v;
      else r.err = 1'b1;
    end else if (q.rail >= NUM_BUCKS) begin
      r.err = 1'b1;
    end else begin
      vo = int'(rail_volts(q.rail, q.code_a, okv));
      vn = int'(rail_volts(q.rail, q.code_b, okv));
      d  = (vo > vn) ? vo - vn : vn - vo;
      r.ramp = 10'((2 * d + int'(STEP_FINE) - 1) / int'(STEP_FINE));
    end
    return r;
  endfunction

  function automatic req_t random_req();
    req_t        q;
    logic [21:0] anchors[9];
    logic [5:0]  c;
    logic [21:0] v;
    logic        okv;
    anchors = '{V_BUCK_BASE, V_BUCK_FINE_TOP, V_BUCK_COARSE, V_BUCK_TOP, V_LDO_BASE,
                V_LDO_TOP, V_B3_TOP, V_COARSE_1, V_COARSE_2};
    if ($urandom_range(0, 99) < 4) q.kind = KIND_BAD;
    else case ($urandom_range(0, 2))
      0: q.kind = KIND_SELECT;
      1: q.kind = KIND_LIST;
      default: q.kind = KIND_RAMP;
    endcase
    q.rail   = ($urandom_range(0, 99) < 6) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
    q.code_a = 6'($urandom_range(0, 63));
    q.code_b = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 3))
      0: q.min_uv = 22'($urandom);
      1: q.min_uv = 22'($urandom_range(0, 3600000));
      default: q.min_uv = anchors[$urandom_range(0, 8)] + 22'($urandom_range(0, 4)) - 22'd2;
    endcase
    // a max right at the chosen code's voltage flips the over-max error either way
    case ($urandom_range(0, 3))
      0, 1: q.max_uv = UV_ALL;
      2: begin
        q.max_uv = 22'($urandom);
        if (q.rail < NUM_RAILS && pick_code(q.rail, q.min_uv, c)) begin
          v = rail_volts(q.rail, c, okv);
          q.max_uv = v + 22'($urandom_range(0, 2)) - 22'd1;
        end
      end
      default: q.max_uv = 22'($urandom);
    endcase
    return q;
  endfunction

  task automatic add_row(input logic [1:0] k, input logic [3:0] r, input logic [21:0] mn,
                         input logic [21:0] mx, input logic [5:0] ca, input logic [5:0] cb,
                         input logic typed, input logic [5:0] c, input logic [21:0] uv,
                         input logic [9:0] rp, input logic e);
    row_t w;
    w.req  = '{k, r, mn, mx, ca, cb};
    w.typed = typed;
    w.want = '{c, uv, rp, e};
    directed_rows.push_back(w);
  endtask

  // one input beat; expectation is queued on the accepting edge
  task automatic send_req(input req_t q, input conv_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= q.kind;
    rail     <= q.rail;
    min_uv   <= q.min_uv;
    max_uv   <= q.max_uv;
    code_a   <= q.code_a;
    code_b   <= q.code_b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_conv.push_back(want);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (expected_conv.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    conv_t got;
    conv_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{code_out, voltage_uv, ramp_units, error};
      if (expected_conv.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected beat: code %0d uv %0d ramp %0d err %0d",
                   got.code, got.uv, got.ramp, got.err);
      end else begin
        want = expected_conv.pop_front();
        if (got.code != want.code || got.uv != want.uv || got.ramp != want.ramp ||
            got.err != want.err) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected code %0d uv %0d ramp %0d err %0d, got %0d %0d %0d %0d",
                     want.code, want.uv, want.ramp, want.err,
                     got.code, got.uv, got.ramp, got.err);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == STALL_MAX) begin
      $display("pmic_voltage_selector_codec regression: fail");
      $finish;
    end
  end

  initial begin
    row_t w;
    // list: scale ends
    add_row(KIND_LIST, 4'd0, '0, '0, 6'd0, 6'd0, 1'b1, '0, 22'd712500, '0, 1'b0);
    add_row(KIND_LIST, 4'd0, '0, '0, CODE_FINE_TOP, 6'd0, 1'b1, '0, V_BUCK_FINE_TOP, '0, 1'b0);
    add_row(KIND_LIST, 4'd1, '0, '0, CODE_COARSE, 6'd0, 1'b1, '0, V_BUCK_COARSE, '0, 1'b0);
    add_row(KIND_LIST, 4'd1, '0, '0, 6'h3e, 6'd0, 1'b1, '0, 22'd2200000, '0, 1'b0);
    add_row(KIND_LIST, 4'd0, '0, '0, CODE_TOP, 6'd0, 1'b1, '0, V_BUCK_TOP, '0, 1'b0);
    add_row(KIND_LIST, RAIL_BUCK2, '0, '0, 6'h3f, 6'd0, 1'b1, '0, V_BUCK2_FIXED, '0, 1'b0);
    add_row(KIND_LIST, RAIL_BUCK3, '0, '0, 6'h3f, 6'd0, 1'b1, '0, V_B3_TOP, '0, 1'b0);
    add_row(KIND_LIST, 4'd9, '0, '0, CODE_LDO_TOP, 6'd0, 1'b1, '0, 22'd3900000, '0, 1'b0);
    // invalid ldo code, rail past the last, kind three
    add_row(KIND_LIST, 4'd4, '0, '0, 6'd32, 6'd0, 1'b1, '0, '0, '0, 1'b1);
    add_row(KIND_LIST, 4'd15, UV_ALL, UV_ALL, 6'h3f, 6'h3f, 1'b1, '0, '0, '0, 1'b1);
    add_row(KIND_BAD, 4'd0, '0, UV_ALL, 6'd0, 6'd0, 1'b1, '0, '0, '0, 1'b1);
    // select
    add_row(KIND_SELECT, 4'd0, '0, UV_ALL, '0, '0, 1'b1, 6'd0, '0, '0, 1'b0);
    add_row(KIND_SELECT, 4'd0, V_BUCK_TOP, UV_ALL, '0, '0, 1'b1, CODE_TOP, '0, '0, 1'b0);
    add_row(KIND_SELECT, 4'd0, V_BUCK_TOP + 22'd1, UV_ALL, '0, '0, 1'b1, '0, '0, '0, 1'b1);
    add_row(KIND_SELECT, 4'd1, 22'd1450001, UV_ALL, '0, '0, 1'b0, '0, '0, '0, 1'b0);
    add_row(KIND_SELECT, 4'd1, 22'd2199999, '0, '0, '0, 1'b1, '0, '0, '0, 1'b1);
    add_row(KIND_SELECT, RAIL_BUCK2, UV_ALL, UV_ALL, '0, '0, 1'b1, 6'd0, '0, '0, 1'b0);
    add_row(KIND_SELECT, RAIL_BUCK3, V_B3_TOP, UV_ALL, '0, '0, 1'b1, CODE_B3_TOP, '0, '0, 1'b0);
    add_row(KIND_SELECT, RAIL_BUCK3, V_B3_TOP + 22'd1, UV_ALL, '0, '0, 1'b1, '0, '0, '0, 1'b1);
    add_row(KIND_SELECT, 4'd5, V_LDO_TOP, UV_ALL, '0, '0, 1'b1, 6'd26, '0, '0, 1'b0);
    add_row(KIND_SELECT, 4'd8, V_LDO_TOP + 22'd1, UV_ALL, '0, '0, 1'b1, '0, '0, '0, 1'b1);
    add_row(KIND_SELECT, 4'd0, 22'd1000000, 22'd1000000, '0, '0, 1'b0, '0, '0, '0, 1'b0);
    // ramp
    add_row(KIND_RAMP, 4'd0, '0, '0, 6'd0, 6'h3f, 1'b1, '0, '0, 10'd254, 1'b0);
    add_row(KIND_RAMP, RAIL_BUCK3, '0, '0, 6'h3f, 6'd0, 1'b1, '0, '0, 10'd432, 1'b0);
    add_row(KIND_RAMP, 4'd4, '0, '0, 6'd0, 6'd31, 1'b1, '0, '0, '0, 1'b1);
    add_row(KIND_RAMP, 4'd1, '0, '0, 6'd1, 6'd0, 1'b0, '0, '0, '0, 1'b0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      w = directed_rows[i];
      send_req(w.req, w.typed ? w.want : convert_beat(w.req));
    end

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        src_idle_pct  = 73;
        snk_stall_pct = 26;
      end else if (phase == 2) begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
      for (int n = 0; n < PHASE_BEATS; n++) begin
        req_t q;
        q = random_req();
        send_req(q, convert_beat(q));
      end
      // let the pipe empty before the next profile
      hold_until_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && expected_conv.size() == 0)
      $display("pmic_voltage_selector_codec regression: pass");
    else
      $display("pmic_voltage_selector_codec regression: fail");
    $finish;
  end

endmodule
